// ===== design/color_sensor_channel_scaler_core_defines.svh =====
// ----------------------------------------------------------------------------
// Color sensor channel scaler: assertion macros
// Shared assertion forms for the scaler core; reset is active low.
// ----------------------------------------------------------------------------
`ifndef COLOR_SENSOR_CHANNEL_SCALER_CORE_DEFINES_SVH
`define COLOR_SENSOR_CHANNEL_SCALER_CORE_DEFINES_SVH

// same-cycle implication
`define CSCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cscs_pkg.sv =====
// ----------------------------------------------------------------------------
// Color sensor channel scaler package
// Widths, constants and control types shared by the scaler core.
// ----------------------------------------------------------------------------
package cscs_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned DivW    = 16;
  localparam int unsigned BinW    = 10;   // saturated quotient, 0..999
  localparam int unsigned BcdW    = 12;   // three BCD digits
  localparam int unsigned CharW   = 6;
  localparam int unsigned StepW   = 4;

  localparam logic [CharW-1:0] DIGIT_BASE = 6'h30;
  localparam logic [BinW-1:0]  SAT_LIMIT  = 10'd999;
  localparam logic [StepW-1:0] DIV_LAST   = 4'd15;
  localparam logic [StepW-1:0] BCD_LAST   = 4'd9;

  // configuration register indexes
  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  // color channels / phases
  localparam logic [1:0] CH_RED    = 2'd0;
  localparam logic [1:0] CH_GREEN  = 2'd1;
  localparam logic [1:0] CH_BLUE   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SAT  = 5'b00100,
    ST_BCD  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

endpackage

// ===== design/color_sensor_channel_scaler_core.sv =====
// Flow: an accepted input word goes through 16 divide steps, 1 saturate
//   step, 10 BCD steps and 1 output load; the load waits while the output
//   register is still held by an untaken word.
// Throughput: a new word is taken only in idle, after the last one is loaded
//   to the output, as set by the bit-serial divider and the bit-serial BCD shifter.
// Reset: rst_n synchronous active low; divisors return to 1, phase to red.
// ----------------------------------------------------------------------------
// Color sensor channel scaler core
// Divides each gate-window pulse count by its channel's calibration divisor,
// saturates at 999, emits three ASCII digits and the next filter select bits.
// ----------------------------------------------------------------------------
`include "color_sensor_channel_scaler_core_defines.svh"

module color_sensor_channel_scaler_core
  import cscs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] pulse_count
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [5:0] hundreds_char, [11:6] tens_char,
                                    // [17:12] units_char, [18] filter_select_a,
                                    // [19] filter_select_b, [23:20] zero
  output logic [2:0]  out_tuser,    // [1:0] channel, [2] overflow
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Calibration divisors. Writes are always taken; index 3 is dropped.
  // --------------------------------------------------------------------------
  logic [DivW-1:0] red_div_r, green_div_r, blue_div_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_div_r   <= {{(DivW-1){1'b0}}, 1'b1};
      green_div_r <= {{(DivW-1){1'b0}}, 1'b1};
      blue_div_r  <= {{(DivW-1){1'b0}}, 1'b1};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RED:   red_div_r   <= cfg_data;
        REG_GREEN: green_div_r <= cfg_data;
        REG_BLUE:  blue_div_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [1:0]      ch_r, ch_nxt;
  logic [DivW-1:0] div_r, div_nxt;
  logic [CountW-1:0] dvd_r, dvd_nxt;   // dividend in, quotient out
  logic [DivW-1:0] rem_r, rem_nxt;
  logic [BinW-1:0] bin_r, bin_nxt;
  logic [BcdW-1:0] bcd_r, bcd_nxt;
  logic            ovf_r, ovf_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [23:0]     out_data_r, out_data_nxt;
  logic [2:0]      out_user_r, out_user_nxt;

  logic            in_acc;
  logic            out_free;

  // divider step: shift one dividend bit into the remainder, trial subtract
  logic [DivW:0]   rem_shift;
  logic [DivW:0]   trial;
  logic            qbit;

  // double-dabble step: digits at 5 or above get +3 before the shift
  logic [BcdW-1:0] bcd_adj;

  // output digits and select pins
  logic [CharW-1:0] h_char, t_char, u_char;
  logic            sel_a, sel_b;
  logic [DivW-1:0] div_pick;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign rem_shift = {rem_r, dvd_r[CountW-1]};
  assign trial     = rem_shift - {1'b0, div_r};
  assign qbit      = !trial[DivW];

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      if (bcd_r[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4];
      end
    end
  end

  assign h_char = DIGIT_BASE + {2'b00, bcd_r[11:8]};
  assign t_char = DIGIT_BASE + {2'b00, bcd_r[7:4]};
  assign u_char = DIGIT_BASE + {2'b00, bcd_r[3:0]};

  // select pins aim the filter at the channel after the one just measured
  always_comb begin
    case (ch_r)
      CH_GREEN: begin sel_a = 1'b0; sel_b = 1'b1; end
      CH_BLUE:  begin sel_a = 1'b0; sel_b = 1'b0; end
      default:  begin sel_a = 1'b1; sel_b = 1'b1; end
    endcase
  end

  // channel, divisor and next phase for the window that just ended;
  // the unused phase code falls back to red
  always_comb begin
    case (phase_r)
      CH_GREEN: begin ch_nxt = CH_GREEN; div_pick = green_div_r; phase_nxt = CH_BLUE;  end
      CH_BLUE:  begin ch_nxt = CH_BLUE;  div_pick = blue_div_r;  phase_nxt = CH_RED;   end
      default:  begin ch_nxt = CH_RED;   div_pick = red_div_r;   phase_nxt = CH_GREEN; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    div_nxt       = div_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // a zero divisor divides as one
          div_nxt   = (div_pick == '0) ? {{(DivW-1){1'b0}}, 1'b1} : div_pick;
          dvd_nxt   = in_tdata;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = qbit ? trial[DivW-1:0] : rem_shift[DivW-1:0];
        dvd_nxt  = {dvd_r[CountW-2:0], qbit};
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (dvd_r > {{(CountW-BinW){1'b0}}, SAT_LIMIT}) begin
          bin_nxt = SAT_LIMIT;
          ovf_nxt = 1'b1;
        end else begin
          bin_nxt = dvd_r[BinW-1:0];
          ovf_nxt = 1'b0;
        end
        bcd_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_BCD;
      end
      ST_BCD: begin
        bcd_nxt  = {bcd_adj[BcdW-2:0], bin_r[BinW-1]};
        bin_nxt  = {bin_r[BinW-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == BCD_LAST) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait here while an earlier word still sits in the output register
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, sel_b, sel_a, u_char, t_char, h_char};
          out_user_nxt  = {ovf_r, ch_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= CH_RED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    div_r      <= div_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    if (in_acc) begin
      ch_r <= ch_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CSCS_ASSERT_NOW(a_ovf_nines, clk, rst_n,
    out_tvalid && out_tuser[2],
    out_tdata[17:0] == {3{DIGIT_BASE + 6'd9}}, "saturated word must read 999")
  `CSCS_ASSERT_NEXT(a_acc_starts_div, clk, rst_n,
    in_acc, state_r == ST_DIV && step_r == '0, "accepted word must start divide")
  `CSCS_ASSERT_NOW(a_phase_legal, clk, rst_n,
    1'b1, phase_r != 2'd3, "phase reached unused code")
  `CSCS_ASSERT_NEXT(a_emit_loads, clk, rst_n,
    state_r == ST_EMIT && out_free, out_tvalid && in_tready,
    "emit must load output and release input")

endmodule
